[hdl/jfs_pkg.sv]
package jfs_pkg;

  localparam logic [3:0] PH_SOI0  = 4'd0;
  localparam logic [3:0] PH_SOI1  = 4'd1;
  localparam logic [3:0] PH_HUNT  = 4'd2;
  localparam logic [3:0] PH_MARK  = 4'd3;
  localparam logic [3:0] PH_LENHI = 4'd4;
  localparam logic [3:0] PH_LENLO = 4'd5;
  localparam logic [3:0] PH_PREC  = 4'd6;
  localparam logic [3:0] PH_HHI   = 4'd7;
  localparam logic [3:0] PH_HLO   = 4'd8;
  localparam logic [3:0] PH_WHI   = 4'd9;
  localparam logic [3:0] PH_WLO   = 4'd10;
  localparam logic [3:0] PH_SKIP  = 4'd11;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_BADLEN = 2'd1;
  localparam logic [1:0] ST_NOTFND = 2'd2;

  localparam logic [7:0]  MARKER_PREFIX  = 8'hFF;
  localparam logic [7:0]  MARKER_FIRST   = 8'hC0;
  localparam logic [7:0]  MARKER_LAST    = 8'hFE;
  localparam logic [15:0] MIN_SEG_LEN    = 16'd2;
  localparam logic [15:0] SOF_HEADER_LEN = 16'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] skip_left;
    logic [15:0] segment_length;
    logic [15:0] height_hold;
    logic [7:0]  high_byte_hold;
    logic [7:0]  current_marker;
    logic        finished;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    phase:          PH_SOI0,
    skip_left:      16'd0,
    segment_length: 16'd0,
    height_hold:    16'd0,
    high_byte_hold: 8'd0,
    current_marker: 8'd0,
    finished:       1'b0
  };

  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC9 && m <= 8'hCB);
  endfunction

endpackage

[hdl/jfs_step.sv]
module jfs_step (
  input  jfs_pkg::scan_t cur,
  input  jfs_pkg::in_t   in_word,
  output jfs_pkg::scan_t nxt,
  output logic           res_valid,
  output jfs_pkg::out_t  res_word
);
  import jfs_pkg::*;

  logic [7:0]  b;
  logic [15:0] pair;

  assign b    = in_word.data_byte;
  assign pair = {cur.high_byte_hold, b};

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res_word  = '0;
    if (!cur.finished) begin
      unique case (cur.phase)
        PH_SOI0: nxt.phase = PH_SOI1;
        PH_SOI1: nxt.phase = PH_HUNT;
        PH_HUNT: begin
          if (b == MARKER_PREFIX) nxt.phase = PH_MARK;
        end
        PH_MARK: begin
          if (b >= MARKER_FIRST && b <= MARKER_LAST) begin
            nxt.current_marker = b;
            nxt.phase          = PH_LENHI;
          end else begin
            nxt.phase = PH_HUNT;
          end
        end
        PH_LENHI: begin
          nxt.high_byte_hold = b;
          nxt.phase          = PH_LENLO;
        end
        PH_LENLO: begin
          nxt.segment_length = pair;
          if (is_frame_marker(cur.current_marker)) begin
            nxt.phase = PH_PREC;
          end else if (pair > MIN_SEG_LEN) begin
            nxt.skip_left = pair - MIN_SEG_LEN;
            nxt.phase     = PH_SKIP;
          end else begin
            res_valid       = 1'b1;
            res_word.status = ST_BADLEN;
            nxt.finished    = 1'b1;
          end
        end
        PH_PREC: nxt.phase = PH_HHI;
        PH_HHI: begin
          nxt.high_byte_hold = b;
          nxt.phase          = PH_HLO;
        end
        PH_HLO: begin
          nxt.height_hold = pair;
          nxt.phase       = PH_WHI;
        end
        PH_WHI: begin
          nxt.high_byte_hold = b;
          nxt.phase          = PH_WLO;
        end
        PH_WLO: begin
          if (pair != 16'd0 && cur.height_hold != 16'd0) begin
            res_valid             = 1'b1;
            res_word.image_width  = pair;
            res_word.image_height = cur.height_hold;
            res_word.status       = ST_FOUND;
            nxt.finished          = 1'b1;
          end else if (cur.segment_length > SOF_HEADER_LEN) begin
            nxt.skip_left = cur.segment_length - SOF_HEADER_LEN;
            nxt.phase     = PH_SKIP;
          end else begin
            nxt.phase = PH_HUNT;
          end
        end
        PH_SKIP: begin
          if (cur.skip_left > 16'd1) begin
            nxt.skip_left = cur.skip_left - 16'd1;
          end else begin
            nxt.skip_left = 16'd0;
            nxt.phase     = PH_HUNT;
          end
        end
        default: nxt.phase = PH_HUNT;
      endcase
    end
    if (in_word.last_byte) begin
      if (!cur.finished && !res_valid) begin
        res_valid       = 1'b1;
        res_word        = '0;
        res_word.status = ST_NOTFND;
      end
      nxt = SCAN_RESET;
    end
  end

endmodule

[hdl/jfs_out_skid.sv]
module jfs_out_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jfs_pkg::out_t push_word,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output jfs_pkg::out_t out_word
);
  import jfs_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic load_out, load_skid, pop;
  out_t out_r, skid_r;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    if (skid_valid_r) begin
      if (pop) begin
        skid_valid_nxt = 1'b0;
        load_out       = 1'b1;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        load_out      = 1'b1;
      end else begin
        skid_valid_nxt = 1'b1;
        load_skid      = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_r <= skid_valid_r ? skid_r : push_word;
    if (load_skid) skid_r <= push_word;
  end

endmodule

[hdl/jpeg_frame_size_scanner.sv]
// JPEG frame size scanner.
// Input channel: one file byte per word (in_data.data_byte) with
// in_data.last_byte set on the final byte of the file. A word is taken on a
// rising edge with in_valid high and in_stall low.
// Output channel: at most one word per file: width, height and status
// (found, bad segment length, or file ended without a size).
// One input word is taken every cycle while in_stall is low; the scanner state
// updates in the accepting cycle and any result is registered, so it shows on
// out_valid from the output register once that register is free. The not-found
// result follows the final byte in the same way.
// When the receiver stalls, the result is held in the output register and a
// second result can wait in a skid register; input keeps flowing until that
// skid register fills, then in_stall rises until the output word is taken.
// Bytes after a result are consumed and dropped until the final byte, which
// returns the scanner to its start state for the next file.
// Reset (rst_n low, synchronous) empties the output side and puts the
// scanner at the first start-of-image byte.
module jpeg_frame_size_scanner (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  jfs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output jfs_pkg::out_t out_data
);
  import jfs_pkg::*;

  scan_t scan_r, scan_nxt;
  out_t  res_word;
  logic  res_valid;
  logic  in_accept;

  assign in_accept = in_valid && !in_stall;

  jfs_step u_step (
    .cur       (scan_r),
    .in_word   (in_data),
    .nxt       (scan_nxt),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= SCAN_RESET;
    end else if (in_accept) begin
      scan_r <= scan_nxt;
    end
  end

  jfs_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && res_valid),
    .push_word (res_word),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_data)
  );

  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no output word pending");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_byte |=> scan_r.phase == PH_SOI0 && !scan_r.finished)
    else $error("scanner not restarted after final byte");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FOUND |->
      out_data.image_width != 16'd0 && out_data.image_height != 16'd0)
    else $error("size reported with a zero dimension");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && scan_r.finished && !in_data.last_byte |-> !res_valid)
    else $error("second result for one file");

endmodule
